FILE: rtl/core/psf_pkg.sv
// psf_pkg: shared widths, codes and defaults of the png sub filter codec
// no dependencies; imported by png_sub_filter_codec, psf_checker and png_sub_filter_codec_test
`timescale 1ns / 1ps

package psf_pkg;

    // field and register widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 15;
    localparam int POS_W   = 15;
    localparam int CFG_A_W = 1;
    localparam int CFG_D_W = 15;
    localparam int USER_W  = 2;

    // parameter defaults
    localparam int BYTES_PER_PIXEL_DEF = 4;
    localparam int MAX_LINE_BYTES_DEF  = 16385;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_SCANLINE_LENGTH = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_DIRECTION       = 1'b1;

    // register reset values
    localparam logic [LEN_W-1:0] LEN_RESET = 15'd5;

    // direction codes
    localparam logic DIR_UNDO  = 1'b0;
    localparam logic DIR_APPLY = 1'b1;

    // filter type byte values
    localparam logic [BYTE_W-1:0] TYPE_NONE = 8'd0;
    localparam logic [BYTE_W-1:0] TYPE_SUB  = 8'd1;

    // line filter state
    typedef logic [1:0] line_filter_t;
    localparam line_filter_t FILT_NONE = 2'd0;
    localparam line_filter_t FILT_SUB  = 2'd1;
    localparam line_filter_t FILT_BAD  = 2'd2;

endpackage

FILE: rtl/core/png_sub_filter_codec.sv
// png_sub_filter_codec: one request in, one result out, per scanline byte
// for an rgba8 png stream; undoes or applies the sub filter
// depends on psf_pkg
//
// usage: each byte of the decompressed stream (type byte first, then the
// samples of the line) enters on s_tdata. every accepted byte yields one
// result on m_tdata; m_tuser[0] marks a filter type byte, m_tuser[1] is the
// sticky unsupported-filter flag. cfg_wr_en writes scanline_length (index 0)
// or direction (index 1, 0 undo, 1 apply) at a rising edge; write only while
// the block is idle.
// the result is registered: m_tvalid rises in the cycle after accept. throughput: one byte per cycle
// while the receiver does not stall, set by the single add/subtract against the pixel history registers.
// stall: s_tready follows m_tready whenever a result is held, so a stalled
// receiver stops input with no loss; the held result stays stable.
// reset (aresetn low, synchronous): the next byte is a type byte, the error
// flag clears, scanline_length returns to 5 and direction to undo. the
// history registers hold no reset value; every slot is written in a line
// before it is read.
`timescale 1ns / 1ps

module png_sub_filter_codec #(
    parameter int BYTES_PER_PIXEL = psf_pkg::BYTES_PER_PIXEL_DEF,
    parameter int MAX_LINE_BYTES  = psf_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [psf_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [psf_pkg::CFG_D_W-1:0]   cfg_wr_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [psf_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psf_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic [psf_pkg::USER_W-1:0]    m_tuser    // [0] is_type_byte, [1] bad_filter
);

    import psf_pkg::*;

    localparam int SLOT_W = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BYTES_PER_PIXEL - 1);
    localparam logic [POS_W:0]    MAX_LEN   = (POS_W + 1)'(MAX_LINE_BYTES);

    // configuration registers
    logic [LEN_W-1:0] scanline_length_reg;
    logic             direction_reg;

    // line state
    logic [POS_W-1:0]  line_position_reg, line_position_next;
    line_filter_t      line_filter_reg, line_filter_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              first_pixel_reg, first_pixel_next;
    logic              error_seen_reg, error_seen_next;
    logic [BYTE_W-1:0] pixel_history [BYTES_PER_PIXEL];

    // result register
    logic              m_tvalid_reg;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              is_type_reg, is_type_next;

    logic              s_fire;
    logic              hist_we;
    logic [BYTE_W-1:0] hist_wdata;
    logic [BYTE_W-1:0] hist_rdata;
    logic [POS_W:0]    pos_inc;
    logic [POS_W:0]    len_eff;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scanline_length_reg <= LEN_RESET;
            direction_reg       <= DIR_UNDO;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_SCANLINE_LENGTH: scanline_length_reg <= cfg_wr_data[LEN_W-1:0];
                CFG_DIRECTION:       direction_reg       <= cfg_wr_data[0];
                default:             ;
            endcase
        end
    end

    // effective line length, capped at the maximum
    always_comb begin
        len_eff = {1'b0, scanline_length_reg};
        if (len_eff > MAX_LEN) begin
            len_eff = MAX_LEN;
        end
    end

    assign hist_rdata = pixel_history[slot_reg];

    // per byte conversion
    always_comb begin
        line_filter_next = line_filter_reg;
        error_seen_next  = error_seen_reg;
        slot_next        = slot_reg;
        first_pixel_next = first_pixel_reg;
        out_byte_next    = s_tdata;
        is_type_next     = 1'b0;
        hist_we          = 1'b0;
        hist_wdata       = s_tdata;

        if (line_position_reg == '0) begin
            // type byte starts a line
            is_type_next     = 1'b1;
            slot_next        = '0;
            first_pixel_next = 1'b1;
            if (s_tdata == TYPE_NONE) begin
                line_filter_next = FILT_NONE;
            end else if (s_tdata == TYPE_SUB) begin
                line_filter_next = FILT_SUB;
            end else begin
                line_filter_next = FILT_BAD;
                error_seen_next  = 1'b1;
            end
        end else begin
            if (line_filter_reg == FILT_SUB) begin
                hist_we = 1'b1;
                if (!first_pixel_reg) begin
                    if (direction_reg == DIR_UNDO) begin
                        out_byte_next = s_tdata + hist_rdata;
                        hist_wdata    = s_tdata + hist_rdata;
                    end else begin
                        out_byte_next = s_tdata - hist_rdata;
                    end
                end
            end
            // track sample slot within the pixel
            if (slot_reg == SLOT_LAST) begin
                slot_next        = '0;
                first_pixel_next = 1'b0;
            end else begin
                slot_next = slot_reg + 1'b1;
            end
        end

        // advance line position
        pos_inc = {1'b0, line_position_reg} + 1'b1;
        if (pos_inc >= len_eff) begin
            line_position_next = '0;
        end else begin
            line_position_next = pos_inc[POS_W-1:0];
        end
    end

    // line state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_position_reg <= '0;
            line_filter_reg   <= FILT_NONE;
            slot_reg          <= '0;
            first_pixel_reg   <= 1'b1;
            error_seen_reg    <= 1'b0;
        end else if (s_fire) begin
            line_position_reg <= line_position_next;
            line_filter_reg   <= line_filter_next;
            slot_reg          <= slot_next;
            first_pixel_reg   <= first_pixel_next;
            error_seen_reg    <= error_seen_next;
        end
    end

    // pixel history, holds unfiltered bytes
    always_ff @(posedge aclk) begin
        if (s_fire && hist_we) begin
            pixel_history[slot_reg] <= hist_wdata;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            out_byte_reg <= out_byte_next;
            is_type_reg  <= is_type_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {error_seen_reg, is_type_reg};

endmodule

FILE: rtl/core/psf_checker.sv
// psf_checker: port-level checks of png_sub_filter_codec over time
// depends on psf_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module psf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    import psf_pkg::*;

    logic seen_bad_reg;

    // remember that a valid result carried the error flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_bad_reg <= 1'b0;
        end else if (m_tvalid && m_tuser[1]) begin
            seen_bad_reg <= 1'b1;
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // error flag is sticky across results
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && seen_bad_reg |-> m_tuser[1])
        else $error("bad_filter dropped");

    // unsupported type byte raises the flag in the same result
    a_bad_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && (m_tdata != TYPE_NONE) && (m_tdata != TYPE_SUB)
        |-> m_tuser[1])
        else $error("unsupported type without bad_filter");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind png_sub_filter_codec psf_checker u_psf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: dv/png_sub_filter_codec_test.sv
// png_sub_filter_codec_test: self-checking bench for the png sub filter codec
// directed table of scanlines, then random lines checked against a local line model
// depends on psf_pkg and png_sub_filter_codec
`timescale 1ns / 1ps

module png_sub_filter_codec_test;

    import psf_pkg::*;

    localparam int PIX_BYTES   = BYTES_PER_PIXEL_DEF;
    localparam int LINE_CAP    = MAX_LINE_BYTES_DEF;
    localparam int RANDOM_BYTES = 500;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_GAP   = 3;

    // one result: converted byte and its two flags
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_type;
        logic              bad;
    } conv_t;

    typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

    // directed row: a byte request or a register write; addr unused on byte rows
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_A_W-1:0]   addr;
        logic [CFG_D_W-1:0]   value;
        logic                 typed;
        conv_t                want;
    } script_row_t;

    localparam int N_ROWS = 30;
    localparam script_row_t DIRECTED [N_ROWS] = '{
        // pass-through line at the reset length, sample extremes
        '{ROW_BYTE, '0, 15'(TYPE_NONE), 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_BYTE, '0, 15'h0ff,        1'b1, '{8'hff, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 15'h000,        1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 15'h080,        1'b1, '{8'h80, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 15'h07f,        1'b1, '{8'h7f, 1'b0, 1'b0}},
        // two-pixel sub line, undo wraps to zero, then apply from mid-line
        '{ROW_REG,  CFG_SCANLINE_LENGTH, 15'd9, 1'b0, '0},
        '{ROW_BYTE, '0, 15'(TYPE_SUB),  1'b1, '{8'h01, 1'b1, 1'b0}},
        '{ROW_BYTE, '0, 15'h0ff,        1'b1, '{8'hff, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 15'h001,        1'b1, '{8'h01, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 15'h080,        1'b1, '{8'h80, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 15'h000,        1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 15'h001,        1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 15'h0ff,        1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_REG,  CFG_DIRECTION, 15'(DIR_APPLY), 1'b0, '0},
        '{ROW_BYTE, '0, 15'h010,        1'b0, '0},
        '{ROW_BYTE, '0, 15'h0ff,        1'b0, '0},
        // line cut short: length drops below the current position
        '{ROW_BYTE, '0, 15'(TYPE_SUB),  1'b1, '{8'h01, 1'b1, 1'b0}},
        '{ROW_BYTE, '0, 15'h000,        1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 15'h0ff,        1'b1, '{8'hff, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 15'h055,        1'b1, '{8'h55, 1'b0, 1'b0}},
        '{ROW_REG,  CFG_SCANLINE_LENGTH, 15'd3, 1'b0, '0},
        '{ROW_BYTE, '0, 15'h022,        1'b1, '{8'h22, 1'b0, 1'b0}},
        // zero and one length: every byte is a type byte
        '{ROW_REG,  CFG_SCANLINE_LENGTH, 15'd0, 1'b0, '0},
        '{ROW_BYTE, '0, 15'(TYPE_NONE), 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_REG,  CFG_SCANLINE_LENGTH, 15'd1, 1'b0, '0},
        '{ROW_BYTE, '0, 15'(TYPE_SUB),  1'b1, '{8'h01, 1'b1, 1'b0}},
        // unsupported types raise the sticky flag
        '{ROW_REG,  CFG_SCANLINE_LENGTH, 15'd2, 1'b0, '0},
        '{ROW_BYTE, '0, 15'h0ff,        1'b1, '{8'hff, 1'b1, 1'b1}},
        '{ROW_BYTE, '0, 15'h012,        1'b1, '{8'h12, 1'b0, 1'b1}},
        '{ROW_BYTE, '0, 15'h002,        1'b1, '{8'h02, 1'b1, 1'b1}}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_A_W-1:0]   cfg_addr;
    logic [CFG_D_W-1:0]   cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;    // [7:0] data_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BYTE_W-1:0]    m_tdata;    // [7:0] out_byte
    logic [USER_W-1:0]    m_tuser;    // [0] is_type_byte, [1] bad_filter

    png_sub_filter_codec i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // line model state and register copies
    logic [LEN_W-1:0]   line_pos;
    line_filter_t       line_kind;
    logic [BYTE_W-1:0]  pix_hist [PIX_BYTES];
    logic               bad_seen;
    logic [LEN_W-1:0]   set_len;
    logic               set_dir;

    conv_t converted_q [$];
    int    mismatches;
    bit    tx_steady;
    bit    rx_steady;
    bit    rx_hold_req;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // one byte through the scanline model
    task automatic convert_byte(input logic [BYTE_W-1:0] b, output conv_t r);
        logic [LEN_W-1:0] cap;
        int               smp;
        int               slot;
        cap = (set_len > LEN_W'(LINE_CAP)) ? LEN_W'(LINE_CAP) : set_len;
        r.data    = b;
        r.is_type = 1'b0;
        if (line_pos == '0) begin
            r.is_type = 1'b1;
            if (b == TYPE_NONE) begin
                line_kind = FILT_NONE;
            end else if (b == TYPE_SUB) begin
                line_kind = FILT_SUB;
            end else begin
                line_kind = FILT_BAD;
                bad_seen  = 1'b1;
            end
        end else if (line_kind == FILT_SUB) begin
            smp  = int'(line_pos) - 1;
            slot = smp % PIX_BYTES;
            if (smp < PIX_BYTES) begin
                pix_hist[slot] = b;
            end else if (set_dir == DIR_UNDO) begin
                r.data         = b + pix_hist[slot];
                pix_hist[slot] = r.data;
            end else begin
                r.data         = b - pix_hist[slot];
                pix_hist[slot] = b;
            end
        end
        line_pos = line_pos + 1'b1;
        if (line_pos >= cap)
            line_pos = '0;
        r.bad = bad_seen;
    endtask

    // offer one byte with random gaps, predict once the request is taken
    task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic typed,
                              input conv_t typed_val);
        conv_t got;
        while (!tx_steady && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        convert_byte(b, got);
        converted_q.insert(converted_q.size(), typed ? typed_val : got);
    endtask

    // stop offering until every pending result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (converted_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_D_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_SCANLINE_LENGTH)
            set_len = val;
        else
            set_dir = val[0];
        @(posedge aclk);
    endtask

    // random stream byte: mostly well-formed type bytes, random samples
    function automatic logic [BYTE_W-1:0] stream_byte();
        int pick;
        pick = $urandom_range(99);
        if (line_pos == '0) begin
            if (pick < 70)
                return TYPE_SUB;
            else if (pick < 90)
                return TYPE_NONE;
            return BYTE_W'($urandom_range(255, 2));
        end
        if (pick < 5)
            return '0;
        else if (pick < 10)
            return '1;
        return BYTE_W'($urandom_range(255));
    endfunction

    // line length for a random phase, mostly whole rgba pixels
    function automatic logic [CFG_D_W-1:0] pick_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return CFG_D_W'($urandom_range(1));
        else if (pick < 20)
            return CFG_D_W'($urandom_range(4, 2));
        else if (pick < 85)
            return CFG_D_W'(PIX_BYTES * $urandom_range(6, 1) + 1);
        return CFG_D_W'($urandom_range(48, 5));
    endfunction

    // stimulus
    initial begin
        conv_t       none;
        int          sent;
        int          phase;
        int          n;
        logic        dir_pick;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        rx_hold_req = 1'b0;
        mismatches  = 0;
        line_pos    = '0;
        line_kind   = FILT_NONE;
        bad_seen    = 1'b0;
        set_len     = LEN_RESET;
        set_dir     = DIR_UNDO;
        none        = '0;
        for (int i = 0; i < PIX_BYTES; i++)
            pix_hist[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_REG) begin
                drain();
                write_reg(DIRECTED[i].addr, DIRECTED[i].value);
            end else begin
                offer_byte(DIRECTED[i].value[BYTE_W-1:0], DIRECTED[i].typed,
                           DIRECTED[i].want);
            end
        end

        // random phases, registers rewritten between them while idle
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BYTES) begin
            drain();
            if ($urandom_range(99) < 85)
                write_reg(CFG_SCANLINE_LENGTH, pick_length());
            if ($urandom_range(99) < 60) begin
                dir_pick = $urandom_range(1) ? DIR_APPLY : DIR_UNDO;
                write_reg(CFG_DIRECTION, CFG_D_W'(dir_pick));
            end
            n = $urandom_range(50, 15);
            if (phase == 2) begin
                // receiver holds off while requests keep coming
                write_reg(CFG_SCANLINE_LENGTH, CFG_D_W'(4 * PIX_BYTES + 1));
                tx_steady   = 1'b1;
                rx_hold_req = 1'b1;
                n = 80;
            end else if (phase == 5) begin
                // both sides busy every cycle
                tx_steady = 1'b1;
                rx_steady = 1'b1;
                n = 120;
            end
            repeat (n) begin
                if ($urandom_range(99) < 2)
                    drain();
                offer_byte(stream_byte(), 1'b0, none);
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            sent  += n;
            phase += 1;
        end

        // longest register value, capped line length, start of a long line
        drain();
        write_reg(CFG_SCANLINE_LENGTH, '1);
        write_reg(CFG_DIRECTION, CFG_D_W'($urandom_range(1)));
        tx_steady = 1'b1;
        offer_byte(TYPE_SUB, 1'b0, none);
        repeat (12)
            offer_byte(BYTE_W'($urandom_range(255)), 1'b0, none);
        tx_steady = 1'b0;

        drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= rx_steady || ($urandom_range(99) >= 17);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        conv_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (converted_q.size() == 0) begin
                $display("%0t unexpected result: out_byte %h user %b", $time, m_tdata,
                         m_tuser);
                mismatches++;
            end else begin
                want = converted_q.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t out_byte: expected %h actual %h", $time, want.data,
                             m_tdata);
                    mismatches++;
                end
                if (m_tuser[0] !== want.is_type) begin
                    $display("%0t is_type_byte: expected %b actual %b", $time,
                             want.is_type, m_tuser[0]);
                    mismatches++;
                end
                if (m_tuser[1] !== want.bad) begin
                    $display("%0t bad_filter: expected %b actual %b", $time, want.bad,
                             m_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no request taken on either side
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

FILE: png_sub_filter_codec.f
rtl/core/psf_pkg.sv
rtl/core/png_sub_filter_codec.sv
rtl/core/psf_checker.sv
dv/png_sub_filter_codec_test.sv
